/* rtl/jsu_pkg.sv */
// Shared types, codes and the UTF-8 encoder for the JSON string unescaper.
// No dependencies; every other file in rtl/ imports this package.
package jsu_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QPtrW      = $clog2(QueueDepth);

   localparam logic [15:0] CapReset = 16'd4096;

   // result kinds seen on the rsp channel
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  kind;
      logic [15:0] out_length;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_DONE,
      TAIL_ERROR
   } tail_type;

   // one decoded request: up to six data bytes, then an optional done/error
   typedef struct packed {
      logic [5:0][7:0] bytes;
      logic [2:0]      nbytes;
      tail_type        tail;
      logic [15:0]     length;
   } cmd_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } utf8_type;

   // Encode a code point as UTF-8; raw passes the low byte through as is.
   function automatic utf8_type utf8_encode(input logic [20:0] cp, input logic raw);
      utf8_type r;
      r.bytes = '0;
      r.len   = 3'd1;
      if (raw || cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.len      = 3'd2;
      end else if (cp < 21'h10000) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.len      = 3'd3;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.len      = 3'd4;
      end
      return r;
   endfunction

endpackage

/* rtl/jsu_front.sv */
// Front end: accepts raw string bytes, runs the escape parser and capacity
// check, and pushes at most one decoded command per request. Depends on jsu_pkg.
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_data,
   input  logic [15:0]      out_capacity,
   output logic             cmd_push,
   output jsu_pkg::cmd_type cmd_data,
   input  logic             cmd_full
);
   import jsu_pkg::*;

   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChU = 8'h75;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_STR,
      PH_ESC,
      PH_HEX,
      PH_PEND,
      PH_PEND_ESC,
      PH_LOHEX
   } phase_type;

   typedef struct packed {
      logic        en;
      logic        raw;
      logic [20:0] cp;
   } slot_type;

   typedef struct packed {
      slot_type  s;
      tail_type  t;
      phase_type ph;
   } step_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] acc_ff, acc_in;
   logic [9:0]  pend_ff, pend_in;
   logic [15:0] stored_ff, stored_in;

   function automatic logic is_hex(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c inside {[8'h30:8'h39]}) v = c[3:0];
      else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) v = c[3:0] + 4'd9;
      return v;
   endfunction

   function automatic step_type string_byte(input logic [7:0] c);
      step_type r;
      r = '{s: '0, t: TAIL_NONE, ph: PH_STR};
      if (c == ChQuote) begin
         r.t  = TAIL_DONE;
         r.ph = PH_IDLE;
      end else if (c == 8'h00) begin
         r.t  = TAIL_ERROR;
         r.ph = PH_IDLE;
      end else if (c == ChBslash) begin
         r.ph = PH_ESC;
      end else begin
         r.s = '{en: 1'b1, raw: 1'b1, cp: {13'd0, c}};
      end
      return r;
   endfunction

   function automatic step_type escape_char(input logic [7:0] c);
      step_type r;
      r = '{s: '{en: 1'b1, raw: 1'b1, cp: {13'd0, c}}, t: TAIL_NONE, ph: PH_STR};
      case (c)
         8'h62: r.s.cp = 21'h08;
         8'h66: r.s.cp = 21'h0C;
         8'h6E: r.s.cp = 21'h0A;
         8'h72: r.s.cp = 21'h0D;
         8'h74: r.s.cp = 21'h09;
         ChU: begin
            r.s.en = 1'b0;
            r.ph   = PH_HEX;
         end
         8'h00: begin
            r.s.en = 1'b0;
            r.t    = TAIL_ERROR;
            r.ph   = PH_IDLE;
         end
         default: ;
      endcase
      return r;
   endfunction

   logic        accept;
   logic [7:0]  c;
   logic [15:0] acc_shift;
   logic [15:0] base;
   slot_type    s1, s2, pend_slot;
   tail_type    tail;
   step_type    r;
   utf8_type    e1, e2;
   logic        fit1, fit2;
   logic [2:0]  n1, n2;
   logic [15:0] cnt1, cnt2;

   assign accept    = req_valid && req_ready;
   assign req_ready = !cmd_full;
   assign c         = req_data.in_byte;
   assign acc_shift = {acc_ff[11:0], hex_val(c)};
   assign pend_slot = '{en: 1'b1, raw: 1'b0, cp: {5'd0, 6'b110110, pend_ff}};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      base     = stored_ff;
      s1       = '0;
      s2       = '0;
      tail     = TAIL_NONE;
      r        = '{s: '0, t: TAIL_NONE, ph: PH_IDLE};
      if (req_data.start_req) begin
         // drop whatever string was in progress
         base    = '0;
         cnt_in  = '0;
         pend_in = '0;
         if (out_capacity == 16'd0 || c != ChQuote) begin
            tail     = TAIL_ERROR;
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_STR;
         end
      end else begin
         case (phase_ff)
            PH_STR: begin
               r        = string_byte(c);
               s1       = r.s;
               tail     = r.t;
               phase_in = r.ph;
            end
            PH_ESC: begin
               r        = escape_char(c);
               s1       = r.s;
               tail     = r.t;
               phase_in = r.ph;
               cnt_in   = '0;
            end
            PH_HEX, PH_LOHEX: begin
               if (!is_hex(c)) begin
                  if (phase_ff == PH_LOHEX) s1 = pend_slot;
                  tail     = TAIL_ERROR;
                  phase_in = PH_IDLE;
               end else begin
                  acc_in = acc_shift;
                  cnt_in = cnt_ff + 2'd1;
                  if (cnt_ff == 2'd3) begin
                     if (phase_ff == PH_LOHEX && acc_shift[15:10] == 6'b110111) begin
                        // combine the surrogate pair
                        s1 = '{en: 1'b1, raw: 1'b0,
                               cp: {1'b0, pend_ff, acc_shift[9:0]} + 21'h10000};
                        phase_in = PH_STR;
                     end else begin
                        if (phase_ff == PH_LOHEX) s1 = pend_slot;
                        if (acc_shift[15:10] == 6'b110110) begin
                           pend_in  = acc_shift[9:0];
                           phase_in = PH_PEND;
                        end else begin
                           if (phase_ff == PH_LOHEX)
                              s2 = '{en: 1'b1, raw: 1'b0, cp: {5'd0, acc_shift}};
                           else
                              s1 = '{en: 1'b1, raw: 1'b0, cp: {5'd0, acc_shift}};
                           phase_in = PH_STR;
                        end
                     end
                  end
               end
            end
            PH_PEND: begin
               if (c == ChBslash) begin
                  phase_in = PH_PEND_ESC;
               end else begin
                  r        = string_byte(c);
                  s1       = pend_slot;
                  s2       = r.s;
                  tail     = r.t;
                  phase_in = r.ph;
               end
            end
            PH_PEND_ESC: begin
               cnt_in = '0;
               if (c == ChU) begin
                  phase_in = PH_LOHEX;
               end else begin
                  r        = escape_char(c);
                  s1       = pend_slot;
                  s2       = r.s;
                  tail     = r.t;
                  phase_in = r.ph;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // capacity check: a character is stored whole or dropped whole
   always_comb begin
      e1   = utf8_encode(s1.cp, s1.raw);
      e2   = utf8_encode(s2.cp, s2.raw);
      fit1 = s1.en && ({2'd0, base} + {15'd0, e1.len} + 18'd1 <= {2'd0, out_capacity});
      n1   = fit1 ? e1.len : 3'd0;
      cnt1 = base + {13'd0, n1};
      fit2 = s2.en && ({2'd0, cnt1} + {15'd0, e2.len} + 18'd1 <= {2'd0, out_capacity});
      n2   = fit2 ? e2.len : 3'd0;
      cnt2 = cnt1 + {13'd0, n2};
   end

   always_comb begin
      logic [2:0] kk;
      logic [2:0] idx2;
      for (int k = 0; k < 6; k++) begin
         kk   = 3'(k);
         idx2 = kk - n1;
         if (kk < n1) cmd_data.bytes[k] = e1.bytes[kk[1:0]];
         else         cmd_data.bytes[k] = e2.bytes[idx2[1:0]];
      end
      cmd_data.nbytes = n1 + n2;
      cmd_data.tail   = tail;
      cmd_data.length = (tail == TAIL_DONE) ? cnt2 : 16'd0;
   end

   assign stored_in = cnt2;
   assign cmd_push  = accept && ((n1 + n2) != 3'd0 || tail != TAIL_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cnt_ff    <= '0;
         acc_ff    <= '0;
         pend_ff   <= '0;
         stored_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         acc_ff    <= acc_in;
         pend_ff   <= pend_in;
         stored_ff <= stored_in;
      end
   end

endmodule

/* rtl/jsu_queue.sv */
// Command queue between the front end and the serializer.
// Small register FIFO of jsu_pkg::cmd_type entries. Depends on jsu_pkg.
module jsu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output jsu_pkg::cmd_type head_data
);
   import jsu_pkg::*;

   cmd_type            mem_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPtrW:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == (QPtrW + 1)'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* rtl/jsu_back.sv */
// Back end: walks the head command one result per cycle into the registered
// rsp output stage while the receiver keeps up. Depends on jsu_pkg.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  jsu_pkg::cmd_type head_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_data
);
   import jsu_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] total;
   logic       load, final_item;

   assign total      = head_data.nbytes + {2'd0, head_data.tail != TAIL_NONE};
   assign final_item = (idx_ff == total - 3'd1);
   assign load       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop        = load && final_item;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (idx_ff < head_data.nbytes) begin
            rsp_data_in.out_byte = head_data.bytes[idx_ff];
            rsp_data_in.kind     = KIND_DATA;
         end else if (head_data.tail == TAIL_DONE) begin
            rsp_data_in.kind       = KIND_DONE;
            rsp_data_in.out_length = head_data.length;
         end else begin
            rsp_data_in.kind = KIND_ERROR;
         end
         rsp_data_in.last = final_item;
         idx_in = final_item ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper: capacity register, front end,
// command queue and serializer. Depends on jsu_pkg and the jsu_* modules.
//
// Usage:
//  - req channel (valid/ready) carries one raw byte of a quoted string per
//    request; start_req marks the opening quote of a new string.
//  - rsp channel (valid/ready) carries results: data bytes (kind 0), a done
//    result with the stored length (kind 1) or an error (kind 2); last flags
//    the final result caused by one request. Dropped bytes give no result.
//  - csr_wr_en/csr_wr_data write out_capacity (buffer size including the
//    terminator); write it only while the block is idle.
// Throughput: one request per cycle while the queue is not full. A request
// yields zero to six results, and the serializer drains one result per
// cycle while the receiver is ready.
// Each result passes through the queue entry, written when the request is
// accepted, and then the output register, loaded from the queue head.
// Reset clears the parser to idle, the queue and the output stage, and loads
// out_capacity with 4096. When the receiver stalls, the output register
// holds, the four-entry queue fills, and req_ready drops once it is full.
module json_string_unescape_utf8 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);
   import jsu_pkg::*;

   logic [15:0] cap_ff;
   logic        cmd_push, cmd_full, cmd_pop, head_valid;
   cmd_type     cmd_data, head_data;

   // hold the capacity register; load it on every write strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // parse and size each request
   jsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .out_capacity (cap_ff),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_data),
      .cmd_full     (cmd_full)
   );

   // decouple parsing from output stalls
   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_data),
      .full       (cmd_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // emit results one per cycle while the receiver is ready
   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (cmd_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/sv/json_string_unescape_utf8_tb.sv */
// Self-checking testbench for json_string_unescape_utf8: directed and random quoted strings,
// checked result by result against an in-bench JSON unescape predictor.
// Depends on jsu_pkg and the RTL of json_string_unescape_utf8 only.
module json_string_unescape_utf8_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jsu_pkg::*;

   localparam int ItemTarget   = 280;   // stop random stimulus around here
   localparam int StallLimit   = 2000;  // cycles with no handshake before giving up
   localparam int SettleCycles = 4;     // request-to-result latency plus margin
   localparam int LongHold     = 80;    // receiver hold-off for the backpressure test

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NUL       = 8'h00;

   // parser position inside a string, as the predictor tracks it
   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_TEXT,
      SCAN_ESCAPE,
      SCAN_HEX,
      SCAN_HELD,
      SCAN_HELD_ESCAPE,
      SCAN_LOW_HEX
   } scan_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // predictor state: capacity register and parser registers
   logic [15:0] capacity   = CapReset;
   scan_type    scan       = SCAN_IDLE;
   int          hex_count  = 0;
   logic [15:0] hex_value  = '0;
   logic [15:0] held_high  = '0;
   logic [15:0] stored     = '0;

   rsp_type     decoded_q[$];      // results still owed by the block, oldest first
   int          fail_count = 0;
   int          sent_count = 0;
   int          quiet_cycles = 0;
   int          sender_gap_max = 8;
   int          sink_gap_max = 8;
   int          sink_hold = 0;     // one-off hold-off request for the receiver

   json_string_unescape_utf8 DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor: unescape one request and queue the results it must produce.
   // ---------------------------------------------------------------------------

   function automatic void note_result(logic [1:0] kind, logic [7:0] b, logic [15:0] len);
      rsp_type r;
      r.out_byte   = b;
      r.kind       = kind;
      r.out_length = len;
      r.last       = 1'b0;
      decoded_q.push_back(r);
   endfunction

   // Drop the string in progress with an error result.
   function automatic void note_error();
      note_result(KIND_ERROR, 8'h00, 16'h0000);
      scan = SCAN_IDLE;
   endfunction

   // Store a single byte while one slot is kept free for the terminator.
   function automatic void put_plain(logic [7:0] b);
      if (int'(stored) + 1 < int'(capacity)) begin
         note_result(KIND_DATA, b, 16'h0000);
         stored = stored + 16'd1;
      end
   endfunction

   // Encode a code point as UTF-8; drop the whole character if it does not fit.
   function automatic void put_code_point(int cp);
      logic [7:0] u [4];
      int w;
      if (cp < 'h80) begin
         u[0] = cp[7:0];
         w = 1;
      end else if (cp < 'h800) begin
         u[0] = 8'hC0 | cp[13:6];
         u[1] = 8'h80 | {2'b00, cp[5:0]};
         w = 2;
      end else if (cp < 'h10000) begin
         u[0] = 8'hE0 | cp[19:12];
         u[1] = 8'h80 | {2'b00, cp[11:6]};
         u[2] = 8'h80 | {2'b00, cp[5:0]};
         w = 3;
      end else begin
         u[0] = 8'hF0 | cp[25:18];
         u[1] = 8'h80 | {2'b00, cp[17:12]};
         u[2] = 8'h80 | {2'b00, cp[11:6]};
         u[3] = 8'h80 | {2'b00, cp[5:0]};
         w = 4;
      end
      if (int'(stored) + w + 1 > int'(capacity)) return;
      for (int k = 0; k < w; k++) begin
         note_result(KIND_DATA, u[k], 16'h0000);
         stored = stored + 16'd1;
      end
   endfunction

   function automatic void take_text(logic [7:0] c);
      if (c == CH_QUOTE) begin
         note_result(KIND_DONE, 8'h00, stored);
         scan = SCAN_IDLE;
      end else if (c == CH_NUL) begin
         note_error();
      end else if (c == CH_BACKSLASH) begin
         scan = SCAN_ESCAPE;
      end else begin
         put_plain(c);
      end
   endfunction

   function automatic void take_escape(logic [7:0] c);
      scan = SCAN_TEXT;
      case (c)
         "b": put_plain(8'h08);
         "f": put_plain(8'h0C);
         "n": put_plain(8'h0A);
         "r": put_plain(8'h0D);
         "t": put_plain(8'h09);
         "u": begin
            scan = SCAN_HEX;
            hex_count = 0;
            hex_value = '0;
         end
         CH_NUL: note_error();
         default: put_plain(c);
      endcase
   endfunction

   // A high surrogate waits for its partner; anything else goes out now.
   function automatic void take_unit(logic [15:0] v);
      if (v >= 16'hD800 && v <= 16'hDBFF) begin
         held_high = v;
         scan = SCAN_HELD;
      end else begin
         put_code_point(int'(v));
         scan = SCAN_TEXT;
      end
   endfunction

   function automatic void decode_request(logic [7:0] c, logic start);
      int n_before;
      int nib;
      rsp_type r;
      n_before = decoded_q.size();
      if (start) begin
         stored = '0;
         hex_count = 0;
         hex_value = '0;
         held_high = '0;
         if (capacity == 16'd0 || c != CH_QUOTE) note_error();
         else scan = SCAN_TEXT;
      end else begin
         case (scan)
            SCAN_TEXT:   take_text(c);
            SCAN_ESCAPE: take_escape(c);
            SCAN_HEX, SCAN_LOW_HEX: begin
               if (c >= "0" && c <= "9") nib = int'(c) - int'("0");
               else if (c >= "a" && c <= "f") nib = int'(c) - int'("a") + 10;
               else if (c >= "A" && c <= "F") nib = int'(c) - int'("A") + 10;
               else nib = -1;
               if (nib < 0) begin
                  // a held high surrogate still goes out ahead of the error
                  if (scan == SCAN_LOW_HEX) put_code_point(int'(held_high));
                  note_error();
               end else begin
                  hex_value = {hex_value[11:0], nib[3:0]};
                  hex_count++;
                  if (hex_count == 4) begin
                     hex_count = 0;
                     if (scan == SCAN_HEX) begin
                        take_unit(hex_value);
                     end else if (hex_value >= 16'hDC00 && hex_value <= 16'hDFFF) begin
                        put_code_point('h10000 + ((int'(held_high) - 'hD800) << 10)
                                       + (int'(hex_value) - 'hDC00));
                        scan = SCAN_TEXT;
                     end else begin
                        put_code_point(int'(held_high));
                        take_unit(hex_value);
                     end
                  end
               end
            end
            SCAN_HELD: begin
               if (c == CH_BACKSLASH) begin
                  scan = SCAN_HELD_ESCAPE;
               end else begin
                  put_code_point(int'(held_high));
                  scan = SCAN_TEXT;
                  take_text(c);
               end
            end
            SCAN_HELD_ESCAPE: begin
               if (c == "u") begin
                  scan = SCAN_LOW_HEX;
                  hex_count = 0;
                  hex_value = '0;
               end else begin
                  put_code_point(int'(held_high));
                  take_escape(c);
               end
            end
            default: scan = SCAN_IDLE;   // idle bytes without start are ignored
         endcase
      end
      // flag the final result of this request
      if (decoded_q.size() > n_before) begin
         r = decoded_q.pop_back();
         r.last = 1'b1;
         decoded_q.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Result checker: compare every accepted result with the oldest prediction.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      rsp_type got;
      bit bad;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_data;
         if (decoded_q.size() == 0) begin
            $error("result with no request pending: kind %0d out_byte %02h out_length %0d",
                   got.kind, got.out_byte, got.out_length);
            fail_count++;
         end else begin
            want = decoded_q.pop_front();
            bad = 1'b0;
            if (got.out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
               bad = 1'b1;
            end
            if (got.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, got.kind);
               bad = 1'b1;
            end
            if (got.out_length !== want.out_length) begin
               $error("out_length: expected %0d, got %0d", want.out_length, got.out_length);
               bad = 1'b1;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, got.last);
               bad = 1'b1;
            end
            if (bad) fail_count++;
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: stall a random number of cycles before each result; honor a
   // one-off long hold-off when a test asks for it, counted here in cycles.
   initial begin : rsp_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold != 0) begin
            stall = sink_hold;
            sink_hold = 0;
         end else begin
            stall = (sink_gap_max == 0) ? 0 : $urandom_range(0, sink_gap_max);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Offer one request after a random gap; hold it until accepted, then predict.
   // Leave valid high so a back-to-back request needs no second assignment.
   task automatic send_req(input logic [7:0] b, input logic start);
      req_type item;
      int gap;
      gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.in_byte   = b;
      item.start_req = start;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      decode_request(b, start);
      sent_count++;
   endtask

   // Drop valid and wait until every predicted result has been checked.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   // Write the capacity register once the block has gone quiet.
   task automatic set_capacity(input logic [15:0] value);
      wait_drained();
      repeat (SettleCycles) @(posedge clock);   // let requests with no result settle
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      capacity = value;
      csr_wr_en <= 1'b0;
   endtask

   // Hex digit in either letter case.
   function automatic logic [7:0] hex_char(logic [3:0] nib);
      logic [7:0] base;
      if (nib < 4'd10) return 8'h30 + {4'h0, nib};
      base = $urandom_range(0, 1) ? 8'h61 : 8'h41;
      return base + {4'h0, nib} - 8'd10;
   endfunction

   function automatic logic [7:0] pick_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
      return c;
   endfunction

   task automatic send_unicode(input logic [15:0] v);
      send_req(CH_BACKSLASH, 1'b0);
      send_req("u", 1'b0);
      for (int k = 3; k >= 0; k--) send_req(hex_char(v[k*4 +: 4]), 1'b0);
   endtask

   // One piece of string content; set ended when it leaves the string closed
   // by an error so the caller drops the closing quote.
   task automatic send_random_token(output bit ended);
      int pick;
      int n;
      logic [7:0] c;
      ended = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
         send_req(c, 1'b0);
      end else if (pick < 50) begin
         send_req(CH_BACKSLASH, 1'b0);
         case ($urandom_range(0, 9))
            0: c = "b";
            1: c = "f";
            2: c = "n";
            3: c = "r";
            4: c = "t";
            5: c = CH_QUOTE;
            6: c = CH_BACKSLASH;
            7: c = "/";
            default: do c = 8'($urandom_range(1, 255)); while (c == "u");
         endcase
         send_req(c, 1'b0);
      end else if (pick < 63) begin
         case ($urandom_range(0, 2))
            0: send_unicode(16'($urandom_range(0, 'h7F)));
            1: send_unicode(16'($urandom_range('h80, 'h7FF)));
            default: send_unicode(16'($urandom_range('h800, 'hFFFF)));
         endcase
      end else if (pick < 78) begin
         send_unicode(16'($urandom_range('hD800, 'hDBFF)));
         send_unicode(16'($urandom_range('hDC00, 'hDFFF)));
      end else if (pick < 88) begin
         // lone high surrogate: whatever comes next decides its fate
         send_unicode(16'($urandom_range('hD800, 'hDBFF)));
      end else if (pick < 95) begin
         send_unicode(16'($urandom_range('hDC00, 'hDFFF)));
      end else begin
         ended = 1'b1;
         case ($urandom_range(0, 5))
            0: send_req(CH_NUL, 1'b0);
            1: begin
               send_req(CH_BACKSLASH, 1'b0);
               send_req(CH_NUL, 1'b0);
            end
            2: begin
               send_req(CH_BACKSLASH, 1'b0);
               send_req("u", 1'b0);
               n = $urandom_range(0, 3);
               repeat (n) send_req(hex_char(4'($urandom_range(0, 15))), 1'b0);
               send_req(pick_non_hex(), 1'b0);
            end
            3: begin
               // high surrogate, then a broken second escape
               send_unicode(16'($urandom_range('hD800, 'hDBFF)));
               send_req(CH_BACKSLASH, 1'b0);
               send_req("u", 1'b0);
               n = $urandom_range(0, 3);
               repeat (n) send_req(hex_char(4'($urandom_range(0, 15))), 1'b0);
               send_req(pick_non_hex(), 1'b0);
            end
            4: begin
               // restart mid-string; the new string carries on
               send_req(CH_QUOTE, 1'b1);
               ended = 1'b0;
            end
            default: begin
               // bad opening byte, then stray bytes while idle
               do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
               send_req(c, 1'b1);
               n = $urandom_range(1, 2);
               repeat (n) send_req(8'($urandom_range(0, 255)), 1'b0);
            end
         endcase
      end
   endtask

   task automatic send_random_string(input int tokens);
      bit ended;
      ended = 1'b0;
      send_req(CH_QUOTE, 1'b1);
      for (int k = 0; k < tokens && !ended; k++) send_random_token(ended);
      if (!ended) send_req(CH_QUOTE, 1'b0);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Field extremes and the special cases, at the reset capacity.
   task automatic test_directed();
      send_req("x", 1'b0);               // idle byte: ignored
      send_req("a", 1'b1);               // start without quote: error
      send_req(CH_QUOTE, 1'b1);
      send_req(8'h01, 1'b0);
      send_req(8'hFF, 1'b0);
      send_req(CH_BACKSLASH, 1'b0);
      send_req("t", 1'b0);
      send_req(CH_QUOTE, 1'b0);          // done, length 3
      send_req(CH_QUOTE, 1'b1);
      send_req(CH_BACKSLASH, 1'b0);
      send_req(CH_NUL, 1'b0);            // NUL after backslash
      send_req(CH_QUOTE, 1'b1);
      send_req(CH_NUL, 1'b0);            // NUL in text
      send_req(CH_QUOTE, 1'b1);
      send_unicode(16'hD800);
      send_req(CH_QUOTE, 1'b0);          // lone high flushed, then done
      send_req(CH_QUOTE, 1'b1);
      send_req(CH_BACKSLASH, 1'b0);
      send_req("u", 1'b0);
      send_req("g", 1'b0);               // bad hex digit
      send_req(CH_QUOTE, 1'b1);
      send_req("z", 1'b0);
      send_req(CH_QUOTE, 1'b1);          // restart drops the string so far
      send_req(CH_QUOTE, 1'b0);
      wait_drained();
   endtask

   // Tiny buffers: single bytes stop at capacity-1, wide characters drop whole.
   task automatic test_capacity_edges();
      for (int v = 1; v <= 6; v++) begin
         set_capacity(v[15:0]);
         send_random_string($urandom_range(2, 5));
      end
      wait_drained();
   endtask

   // Hold the receiver off while the sender keeps going, so the block fills.
   task automatic test_backpressure();
      set_capacity(16'hFFFF);
      sender_gap_max = 0;
      sink_gap_max = 0;
      sink_hold = LongHold;
      send_req(CH_QUOTE, 1'b1);
      repeat (4) send_unicode(16'($urandom_range('h800, 'hFFFF)));
      repeat (2) begin
         send_unicode(16'($urandom_range('hD800, 'hDBFF)));
         send_unicode(16'($urandom_range('hDC00, 'hDFFF)));
      end
      send_req(CH_QUOTE, 1'b0);
      wait_drained();
      sender_gap_max = 8;
      sink_gap_max = 8;
   endtask

   // Pause the sender mid-string until everything is out, and shrink the
   // capacity while a string is open.
   task automatic test_sender_pause();
      set_capacity(16'd4096);
      send_req(CH_QUOTE, 1'b1);
      send_req("p", 1'b0);
      send_unicode(16'h0000);            // encoded NUL is data, not an error
      wait_drained();
      send_unicode(16'hDBFF);            // held until the next escape
      wait_drained();
      send_unicode(16'hDFFF);            // completes the pair
      set_capacity(16'd4);               // applies from the next byte on
      send_req("q", 1'b0);
      send_req(CH_QUOTE, 1'b0);
      wait_drained();
   endtask

   // Mixed traffic with shifting idle patterns and capacities.
   task automatic test_random_mix();
      while (sent_count < ItemTarget) begin
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) set_capacity(16'($urandom_range(1, 40)));
            else set_capacity(16'($urandom_range(41, 'hFFFF)));
         end
         sender_gap_max = $urandom_range(0, 1) ? 8 : 0;
         sink_gap_max   = $urandom_range(0, 1) ? 8 : 0;
         send_random_string($urandom_range(0, 10));
      end
      wait_drained();
   endtask

   initial begin : run_tests
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_capacity_edges();
      test_backpressure();
      test_sender_pause();
      test_random_mix();
      wait_drained();
      repeat (10) @(posedge clock);      // catch any stray result
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
